// ===== rtl/core/d2q5_pkg.sv =====
`default_nettype none
package d2q5_pkg;

  // Field and register widths
  localparam int D_W       = 32;
  localparam int CW        = 17;
  localparam int TW        = 18;
  localparam int CFG_DW    = 18;
  localparam int CFG_IDX_W = 3;
  localparam int RHO_W     = D_W + 3;
  localparam int J_W       = D_W + 1;
  localparam int N_DIR     = 5;

  // Lane order
  localparam int DIR_REST  = 0;
  localparam int DIR_EAST  = 1;
  localparam int DIR_NORTH = 2;
  localparam int DIR_WEST  = 3;
  localparam int DIR_SOUTH = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REST_COEFF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVING_COEFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_C_SQUARED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_TAU      = 3'd3;

  // Register reset values
  localparam logic [CW-1:0] RST_REST_COEFF   = 17'd32768;
  localparam logic [CW-1:0] RST_MOVING_COEFF = 17'd32768;
  localparam logic [CW-1:0] RST_C_SQUARED    = 17'd16384;
  localparam logic [TW-1:0] RST_INV_TAU      = 18'd131072;

  typedef logic signed [D_W-1:0] data_t;

  localparam data_t SAT_MAX = {1'b0, {(D_W-1){1'b1}}};
  localparam data_t SAT_MIN = {1'b1, {(D_W-1){1'b0}}};

  typedef struct packed {
    data_t f_rest;
    data_t f_east;
    data_t f_north;
    data_t f_west;
    data_t f_south;
    logic  is_source_cell;
    data_t source_density;
  } in_item_t;

  typedef struct packed {
    data_t new_rest;
    data_t new_east;
    data_t new_north;
    data_t new_west;
    data_t new_south;
  } out_item_t;

  typedef struct packed {
    logic [CW-1:0] rest_coeff;
    logic [CW-1:0] moving_coeff;
    logic [CW-1:0] c_squared;
    logic [TW-1:0] inv_tau;
  } cfg_t;

  typedef struct packed {
    logic       space;
    logic [1:0] count;
  } merge_st_t;

  function automatic int max_i(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/d2q5_chan_if.sv =====
`default_nettype none
interface d2q5_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/d2q5_moments.sv =====
`default_nettype none
module d2q5_moments #(
  parameter int FRAC_BITS = 16,
  localparam int BASE_W = d2q5_pkg::CW + 1 + d2q5_pkg::RHO_W - FRAC_BITS
) (
  input  logic                                       clk,
  input  logic                                       adv,
  input  d2q5_pkg::in_item_t                         item,
  input  logic [d2q5_pkg::CW-1:0]                    c_squared,
  output d2q5_pkg::data_t [d2q5_pkg::N_DIR-1:0]      f_o,
  output logic signed [d2q5_pkg::RHO_W-1:0]          rho_o,
  output logic signed [BASE_W-1:0]                   base_o,
  output logic signed [d2q5_pkg::J_W-1:0]            jx_o,
  output logic signed [d2q5_pkg::J_W-1:0]            jy_o,
  output logic                                       src_o
);
  import d2q5_pkg::*;

  localparam int BP_W = CW + 1 + RHO_W;

  logic signed [RHO_W-1:0] sum;
  logic signed [RHO_W-1:0] rho_nxt;
  logic signed [J_W-1:0]   jx_nxt;
  logic signed [J_W-1:0]   jy_nxt;
  logic signed [BP_W-1:0]  bp_nxt;
  logic signed [CW:0]      c2_s;

  data_t [N_DIR-1:0]       f1_r;
  logic signed [RHO_W-1:0] rho1_r;
  logic signed [J_W-1:0]   jx1_r;
  logic signed [J_W-1:0]   jy1_r;
  logic                    src1_r;

  data_t [N_DIR-1:0]       f2_r;
  logic signed [RHO_W-1:0] rho2_r;
  logic signed [BP_W-1:0]  bp_r;
  logic signed [J_W-1:0]   jx2_r;
  logic signed [J_W-1:0]   jy2_r;
  logic                    src2_r;

  // Density and momenta; a source cell takes the imposed density
  always_comb begin
    sum = RHO_W'($signed(item.f_rest)) + RHO_W'($signed(item.f_east))
        + RHO_W'($signed(item.f_north)) + RHO_W'($signed(item.f_west))
        + RHO_W'($signed(item.f_south));
    rho_nxt = item.is_source_cell ? RHO_W'($signed(item.source_density)) : sum;
    jx_nxt  = J_W'($signed(item.f_east)) - J_W'($signed(item.f_west));
    jy_nxt  = J_W'($signed(item.f_north)) - J_W'($signed(item.f_south));
  end

  // Stage one: hold sums and distributions
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r[DIR_REST]  <= item.f_rest;
      f1_r[DIR_EAST]  <= item.f_east;
      f1_r[DIR_NORTH] <= item.f_north;
      f1_r[DIR_WEST]  <= item.f_west;
      f1_r[DIR_SOUTH] <= item.f_south;
      rho1_r          <= rho_nxt;
      jx1_r           <= jx_nxt;
      jy1_r           <= jy_nxt;
      src1_r          <= item.is_source_cell;
    end
  end

  // Stage two: scale density by the squared wave speed
  assign c2_s   = $signed({1'b0, c_squared});
  assign bp_nxt = c2_s * rho1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_r   <= f1_r;
      rho2_r <= rho1_r;
      bp_r   <= bp_nxt;
      jx2_r  <= jx1_r;
      jy2_r  <= jy1_r;
      src2_r <= src1_r;
    end
  end

  // Floor by the fraction: drop the low bits of the signed product
  assign base_o = bp_r[BP_W-1:FRAC_BITS];
  assign f_o    = f2_r;
  assign rho_o  = rho2_r;
  assign jx_o   = jx2_r;
  assign jy_o   = jy2_r;
  assign src_o  = src2_r;

endmodule
`default_nettype wire

// ===== rtl/core/d2q5_lane.sv =====
`default_nettype none
module d2q5_lane #(
  parameter int FRAC_BITS = 16,
  parameter int A_W       = 38
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic [d2q5_pkg::CW-1:0]         coef,
  input  logic [d2q5_pkg::TW-1:0]         inv_tau,
  input  d2q5_pkg::data_t                 f,
  input  logic signed [A_W-1:0]           a,
  input  logic signed [d2q5_pkg::J_W-1:0] b,
  input  logic                            sub,
  input  logic                            src,
  output d2q5_pkg::data_t                 res
);
  import d2q5_pkg::*;

  localparam int X_W   = A_W + 1;
  localparam int PW    = CW + 1 + X_W;
  localparam int EQ_W  = PW - FRAC_BITS;
  localparam int KW    = max_i(FRAC_BITS + 1, TW) + 1;
  localparam int PA_W  = KW + D_W;
  localparam int PB_W  = TW + 1 + EQ_W;
  localparam int S_W   = max_i(PA_W, PB_W) + 1;
  localparam int SH_W  = S_W - FRAC_BITS;
  localparam int SAT_W = max_i(SH_W, EQ_W);

  logic signed [X_W-1:0]   x_nxt;
  logic signed [CW:0]      coef_s;
  logic signed [PW-1:0]    p_nxt;
  logic signed [EQ_W-1:0]  eq;
  logic signed [KW-1:0]    keep;
  logic signed [TW:0]      tau_s;
  logic signed [PA_W-1:0]  pa_nxt;
  logic signed [PB_W-1:0]  pb_nxt;
  logic signed [S_W-1:0]   sum;
  logic signed [SH_W-1:0]  sh;
  logic signed [SAT_W-1:0] v;
  logic [SAT_W-D_W:0]      top_bits;
  data_t                   res_nxt;

  logic signed [X_W-1:0]   x_r;
  data_t                   fa_r;
  logic                    srca_r;
  logic signed [PW-1:0]    p_r;
  data_t                   fb_r;
  logic                    srcb_r;
  logic signed [PA_W-1:0]  pa_r;
  logic signed [PB_W-1:0]  pb_r;
  logic signed [EQ_W-1:0]  eq_r;
  logic                    srcc_r;
  data_t                   res_r;

  // Stage one: equilibrium argument, base plus or minus momentum
  assign x_nxt = sub ? (X_W'(a) - X_W'(b)) : (X_W'(a) + X_W'(b));

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r    <= x_nxt;
      fa_r   <= f;
      srca_r <= src;
    end
  end

  // Stage two: weight the argument
  assign coef_s = $signed({1'b0, coef});
  assign p_nxt  = coef_s * x_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r    <= p_nxt;
      fb_r   <= fa_r;
      srcb_r <= srca_r;
    end
  end

  // Stage three: floor to equilibrium, form both relaxation products
  assign eq     = p_r[PW-1:FRAC_BITS];
  assign keep   = $signed(KW'(1) << FRAC_BITS) - $signed(KW'(inv_tau));
  assign tau_s  = $signed({1'b0, inv_tau});
  assign pa_nxt = keep * fb_r;
  assign pb_nxt = tau_s * eq;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      eq_r   <= eq;
      srcc_r <= srcb_r;
    end
  end

  // Stage four: blend, floor, pick equilibrium for a source cell, saturate
  always_comb begin
    sum      = S_W'(pa_r) + S_W'(pb_r);
    sh       = sum[S_W-1:FRAC_BITS];
    v        = srcc_r ? SAT_W'(eq_r) : SAT_W'(sh);
    top_bits = v[SAT_W-1:D_W-1];
    if ((&top_bits) || (~|top_bits)) begin
      res_nxt = v[D_W-1:0];
    end else if (v[SAT_W-1]) begin
      res_nxt = SAT_MIN;
    end else begin
      res_nxt = SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== rtl/core/d2q5_merge.sv =====
`default_nettype none
module d2q5_merge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  d2q5_pkg::data_t [d2q5_pkg::N_DIR-1:0] lane_res,
  d2q5_chan_if.source                           out_ch,
  output d2q5_pkg::merge_st_t                   st
);
  import d2q5_pkg::*;

  out_item_t  item;
  out_item_t  slot_r [2];
  logic       head_r;
  logic       tail_r;
  logic [1:0] cnt_r;
  logic       head_nxt;
  logic       tail_nxt;
  logic [1:0] cnt_nxt;
  logic       pop;

  // Gather the five lanes into one result
  always_comb begin
    item.new_rest  = lane_res[DIR_REST];
    item.new_east  = lane_res[DIR_EAST];
    item.new_north = lane_res[DIR_NORTH];
    item.new_west  = lane_res[DIR_WEST];
    item.new_south = lane_res[DIR_SOUTH];
  end

  assign pop = out_ch.valid & out_ch.ready;

  always_comb begin
    head_nxt = pop ? ~head_r : head_r;
    tail_nxt = push ? ~tail_r : tail_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Two-entry output buffer: pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 1'b0;
      tail_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= item;
    end
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.data  = slot_r[head_r];
  assign st.space     = (cnt_r != 2'd2);
  assign st.count     = cnt_r;

endmodule
`default_nettype wire

// ===== rtl/core/d2q5_wave_collision_cell.sv =====
`default_nettype none
// channel | dir | payload                                        | transfer when
// --------+-----+------------------------------------------------+----------------
// in_ch   | in  | f_rest..f_south, is_source_cell, source_density | valid && ready
// out_ch  | out | new_rest, new_east, new_north, new_west, new_south | valid && ready
// cfg_*   | in  | cfg_index, cfg_wdata                           | cfg_we
//
// One cell per cycle sustained while the output buffer has room. A result passes from its input
// transfer through two moment stages (one multiplier in the second), four stages in
// each of five parallel lanes (multipliers in the second and third), then the
// output buffer.
// rst_n is synchronous and restores the registers to their reset values.
// A stalled output fills the two-entry buffer; ready drops only when it is full or rst_n is low.
module d2q5_wave_collision_cell #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  d2q5_chan_if.sink                         in_ch,
  d2q5_chan_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [d2q5_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [d2q5_pkg::CFG_DW-1:0]       cfg_wdata
);
  import d2q5_pkg::*;

  localparam int BASE_W = CW + 1 + RHO_W - FRAC_BITS;
  localparam int A_W    = max_i(BASE_W, RHO_W);
  localparam int LAT    = 6;

  cfg_t                    cfg_r;
  logic [LAT-1:0]          vld_r;
  logic                    adv;
  logic                    in_fire;
  logic                    push;
  logic                    pop;
  merge_st_t               mst;

  data_t [N_DIR-1:0]       f2;
  logic signed [RHO_W-1:0] rho2;
  logic signed [BASE_W-1:0] base2;
  logic signed [J_W-1:0]   jx2;
  logic signed [J_W-1:0]   jy2;
  logic                    src2;
  data_t [N_DIR-1:0]       lane_res;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_coeff   <= RST_REST_COEFF;
      cfg_r.moving_coeff <= RST_MOVING_COEFF;
      cfg_r.c_squared    <= RST_C_SQUARED;
      cfg_r.inv_tau      <= RST_INV_TAU;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REST_COEFF:   cfg_r.rest_coeff   <= cfg_wdata[CW-1:0];
        CFG_MOVING_COEFF: cfg_r.moving_coeff <= cfg_wdata[CW-1:0];
        CFG_C_SQUARED:    cfg_r.c_squared    <= cfg_wdata[CW-1:0];
        CFG_INV_TAU:      cfg_r.inv_tau      <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline while the output buffer has room
  assign adv         = mst.space;
  assign in_ch.ready = adv & rst_n;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign push        = adv & vld_r[LAT-1];
  assign pop         = out_ch.valid & out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_fire};
    end
  end

  d2q5_moments #(.FRAC_BITS(FRAC_BITS)) u_moments (
    .clk       (clk),
    .adv       (adv),
    .item      (in_ch.data),
    .c_squared (cfg_r.c_squared),
    .f_o       (f2),
    .rho_o     (rho2),
    .base_o    (base2),
    .jx_o      (jx2),
    .jy_o      (jy2),
    .src_o     (src2)
  );

  // Rest lane weights the density itself
  d2q5_lane #(.FRAC_BITS(FRAC_BITS), .A_W(A_W)) u_lane_rest (
    .clk     (clk),
    .adv     (adv),
    .coef    (cfg_r.rest_coeff),
    .inv_tau (cfg_r.inv_tau),
    .f       (f2[DIR_REST]),
    .a       (A_W'(rho2)),
    .b       ('0),
    .sub     (1'b0),
    .src     (src2),
    .res     (lane_res[DIR_REST])
  );

  d2q5_lane #(.FRAC_BITS(FRAC_BITS), .A_W(A_W)) u_lane_east (
    .clk     (clk),
    .adv     (adv),
    .coef    (cfg_r.moving_coeff),
    .inv_tau (cfg_r.inv_tau),
    .f       (f2[DIR_EAST]),
    .a       (A_W'(base2)),
    .b       (jx2),
    .sub     (1'b0),
    .src     (src2),
    .res     (lane_res[DIR_EAST])
  );

  d2q5_lane #(.FRAC_BITS(FRAC_BITS), .A_W(A_W)) u_lane_north (
    .clk     (clk),
    .adv     (adv),
    .coef    (cfg_r.moving_coeff),
    .inv_tau (cfg_r.inv_tau),
    .f       (f2[DIR_NORTH]),
    .a       (A_W'(base2)),
    .b       (jy2),
    .sub     (1'b0),
    .src     (src2),
    .res     (lane_res[DIR_NORTH])
  );

  d2q5_lane #(.FRAC_BITS(FRAC_BITS), .A_W(A_W)) u_lane_west (
    .clk     (clk),
    .adv     (adv),
    .coef    (cfg_r.moving_coeff),
    .inv_tau (cfg_r.inv_tau),
    .f       (f2[DIR_WEST]),
    .a       (A_W'(base2)),
    .b       (jx2),
    .sub     (1'b1),
    .src     (src2),
    .res     (lane_res[DIR_WEST])
  );

  d2q5_lane #(.FRAC_BITS(FRAC_BITS), .A_W(A_W)) u_lane_south (
    .clk     (clk),
    .adv     (adv),
    .coef    (cfg_r.moving_coeff),
    .inv_tau (cfg_r.inv_tau),
    .f       (f2[DIR_SOUTH]),
    .a       (A_W'(base2)),
    .b       (jy2),
    .sub     (1'b1),
    .src     (src2),
    .res     (lane_res[DIR_SOUTH])
  );

  d2q5_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .lane_res (lane_res),
    .out_ch   (out_ch),
    .st       (mst)
  );

`ifndef SYNTH
  // A full buffer must hold off new transfers
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (mst.count == 2'd2) |-> !in_ch.ready)
    else $error("input taken while output buffer full");

  // The buffer never holds more than two results
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mst.count != 2'd3)
    else $error("output buffer overfilled");

  // A push without a pop grows the fill by exactly one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (mst.count == $past(mst.count) + 2'd1))
    else $error("pipeline result lost at output buffer");
`endif

endmodule
`default_nettype wire

// ===== verif/d2q5_wave_collision_cell_test.sv =====
`timescale 1ns / 1ps
module d2q5_wave_collision_cell_test;
  import d2q5_pkg::*;

  localparam int FRAC         = 16;
  localparam int WAIT_MAX     = 11;
  localparam int QUIET_MAX    = 1000;
  localparam int SETTLE       = 16;
  localparam int RAND_PER_SET = 220;
  localparam int N_SETS       = 8;
  localparam data_t ONE       = data_t'(1 << FRAC);
  // First index past the register file; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_INV_TAU + 1'b1;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  d2q5_chan_if #(.T(in_item_t))  in_ch_if ();
  d2q5_chan_if #(.T(out_item_t)) out_ch_if ();

  d2q5_wave_collision_cell #(.FRAC_BITS(FRAC)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch_if),
    .out_ch    (out_ch_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the coefficient registers, pending cells, predicted results
  cfg_t      coeffs;
  in_item_t  cells_q[$];
  out_item_t post_collision_q[$];
  out_item_t want;
  int        cells_made = 0;
  int        results_seen = 0;
  int        errors = 0;
  int        quiet = 0;
  int        send_gap;
  int        recv_stall;
  bit        send_steady;
  bit        recv_steady;

  always #5 clk = ~clk;

  function automatic int draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic data_t clamp(input longint v);
    if (v > longint'(SAT_MAX)) return SAT_MAX;
    if (v < longint'(SAT_MIN)) return SAT_MIN;
    return data_t'(v);
  endfunction

  // BGK collision of one cell; arithmetic shifts on signed values give floor division
  function automatic out_item_t collide(input in_item_t c, input cfg_t k);
    longint    f [N_DIR];
    longint    eq [N_DIR];
    longint    rho, jx, jy, base, keep;
    data_t     lane [N_DIR];
    out_item_t o;
    f[DIR_REST]  = longint'(c.f_rest);
    f[DIR_EAST]  = longint'(c.f_east);
    f[DIR_NORTH] = longint'(c.f_north);
    f[DIR_WEST]  = longint'(c.f_west);
    f[DIR_SOUTH] = longint'(c.f_south);
    rho = f[DIR_REST] + f[DIR_EAST] + f[DIR_NORTH] + f[DIR_WEST] + f[DIR_SOUTH];
    jx  = f[DIR_EAST] - f[DIR_WEST];
    jy  = f[DIR_NORTH] - f[DIR_SOUTH];
    // Source cells take the imposed density but keep their own momentum
    if (c.is_source_cell) rho = longint'(c.source_density);
    eq[DIR_REST]  = (longint'(k.rest_coeff) * rho) >>> FRAC;
    base          = (longint'(k.c_squared) * rho) >>> FRAC;
    eq[DIR_EAST]  = (longint'(k.moving_coeff) * (base + jx)) >>> FRAC;
    eq[DIR_NORTH] = (longint'(k.moving_coeff) * (base + jy)) >>> FRAC;
    eq[DIR_WEST]  = (longint'(k.moving_coeff) * (base - jx)) >>> FRAC;
    eq[DIR_SOUTH] = (longint'(k.moving_coeff) * (base - jy)) >>> FRAC;
    // inv_tau above one turns the keep factor negative
    keep = (longint'(1) << FRAC) - longint'(k.inv_tau);
    for (int d = 0; d < N_DIR; d++) begin
      if (c.is_source_cell)
        lane[d] = clamp(eq[d]);
      else
        lane[d] = clamp((keep * f[d] + longint'(k.inv_tau) * eq[d]) >>> FRAC);
    end
    o.new_rest  = lane[DIR_REST];
    o.new_east  = lane[DIR_EAST];
    o.new_north = lane[DIR_NORTH];
    o.new_west  = lane[DIR_WEST];
    o.new_south = lane[DIR_SOUTH];
    return o;
  endfunction

  // Mostly lattice-sized values, with extremes and full-range words mixed in
  function automatic data_t rand_value();
    case ($urandom_range(0, 9))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2, 3, 4: return data_t'($urandom);
      default: return data_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  task automatic queue_cell(input data_t r, input data_t e, input data_t n, input data_t w,
                            input data_t s, input logic src, input data_t dens);
    in_item_t c;
    c.f_rest         = r;
    c.f_east         = e;
    c.f_north        = n;
    c.f_west         = w;
    c.f_south        = s;
    c.is_source_cell = src;
    c.source_density = dens;
    cells_q.push_back(c);
    cells_made++;
  endtask

  task automatic queue_random_cell();
    queue_cell(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
               $urandom_range(0, 3) == 0, rand_value());
  endtask

  task automatic check_lane(input string lane, input data_t want_v, input data_t got_v);
    if (got_v !== want_v) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, lane, want_v, got_v);
      errors++;
    end
  endtask

  // Write one register; the shadow follows once the edge has taken it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_REST_COEFF:   coeffs.rest_coeff   = val[CW-1:0];
      CFG_MOVING_COEFF: coeffs.moving_coeff = val[CW-1:0];
      CFG_C_SQUARED:    coeffs.c_squared    = val[CW-1:0];
      CFG_INV_TAU:      coeffs.inv_tau      = val[TW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_coeffs(input logic [CFG_DW-1:0] rest, input logic [CFG_DW-1:0] moving,
                                input logic [CFG_DW-1:0] c2, input logic [CFG_DW-1:0] itau);
    write_reg(CFG_REST_COEFF, rest);
    write_reg(CFG_MOVING_COEFF, moving);
    write_reg(CFG_C_SQUARED, c2);
    write_reg(CFG_INV_TAU, itau);
    write_reg(CFG_IDX_SPARE + CFG_IDX_W'($urandom_range(0, 3)), CFG_DW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Block is idle once every queued cell has come back
  task automatic drain();
    while (results_seen != cells_made) @(posedge clk);
  endtask

  // Input driver: present cells with a random gap after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch_if.valid && in_ch_if.ready)
        post_collision_q.push_back(collide(in_ch_if.data, coeffs));
      if (!in_ch_if.valid || in_ch_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch_if.valid <= 1'b0;
        end else if (cells_q.size() > 0) begin
          in_ch_if.data  <= cells_q.pop_front();
          in_ch_if.valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          send_gap = draw_wait(send_steady);
        end else begin
          in_ch_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each transfer, then stall ready for a random stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch_if.valid && out_ch_if.ready) begin
        if (post_collision_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, out_ch_if.data);
          errors++;
        end else begin
          want = post_collision_q.pop_front();
          check_lane("new_rest", want.new_rest, out_ch_if.data.new_rest);
          check_lane("new_east", want.new_east, out_ch_if.data.new_east);
          check_lane("new_north", want.new_north, out_ch_if.data.new_north);
          check_lane("new_west", want.new_west, out_ch_if.data.new_west);
          check_lane("new_south", want.new_south, out_ch_if.data.new_south);
          results_seen++;
        end
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        recv_stall = draw_wait(recv_steady);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch_if.ready <= 1'b0;
      end else begin
        out_ch_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_ch_if.valid && in_ch_if.ready) || (out_ch_if.valid && out_ch_if.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("d2q5_wave_collision_cell_test: FAIL");
      $finish;
    end
  end

  initial begin
    in_ch_if.valid  = 1'b0;
    in_ch_if.data   = '0;
    out_ch_if.ready = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_REST_COEFF;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    send_steady     = 1'b0;
    recv_steady     = 1'b0;
    coeffs.rest_coeff   = RST_REST_COEFF;
    coeffs.moving_coeff = RST_MOVING_COEFF;
    coeffs.c_squared    = RST_C_SQUARED;
    coeffs.inv_tau      = RST_INV_TAU;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < N_SETS; p++) begin
      // Walk through reset values, both extremes, typical and random settings
      case (p)
        0: ;
        1: program_coeffs(18'd0, 18'd0, 18'd0, 18'd0);
        2: program_coeffs(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h3FFFF);
        3: program_coeffs(18'd65536, 18'd65536, 18'd65536, 18'd131072);
        4: program_coeffs(18'd32768, 18'd21845, 18'd21845, 18'd65536);
        5: program_coeffs(18'd49152, 18'd43690, 18'd8192, 18'd1);
        default: program_coeffs(CFG_DW'($urandom), CFG_DW'($urandom),
                                CFG_DW'($urandom), CFG_DW'($urandom));
      endcase

      if (p == 0) begin
        queue_cell(0, 0, 0, 0, 0, 1'b0, 0);
        queue_cell(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b0, 0);
        queue_cell(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b0, 0);
        queue_cell(0, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, 1'b0, 0);
        queue_cell(0, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, 1'b0, 0);
        queue_cell(ONE, ONE, ONE, ONE, ONE, 1'b0, 0);
        queue_cell(-1, -1, -1, -1, -1, 1'b0, -1);
        queue_cell('hAAAAAAAA, 'h55555555, 'hAAAAAAAA, 'h55555555, 'hAAAAAAAA, 1'b0,
                   'h55555555);
        queue_cell('h55555555, 'hAAAAAAAA, 'h55555555, 'hAAAAAAAA, 'h55555555, 1'b1,
                   'hAAAAAAAA);
        // Density is ignored on an ordinary cell
        queue_cell(ONE, 0, 0, 0, 0, 1'b0, SAT_MAX);
        // Source cells: imposed density, momentum still from the cell
        queue_cell(0, 0, 0, 0, 0, 1'b1, SAT_MAX);
        queue_cell(0, 0, 0, 0, 0, 1'b1, SAT_MIN);
        queue_cell(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MAX, 1'b1, 0);
        queue_cell(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1, SAT_MAX);
        queue_cell(ONE, -ONE, ONE, ONE, -ONE, 1'b1, -1);
      end

      repeat (RAND_PER_SET) queue_random_cell();
      drain();
    end

    // Let any stray result surface before the verdict
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("d2q5_wave_collision_cell_test: PASS");
    else
      $display("d2q5_wave_collision_cell_test: FAIL");
    $finish;
  end

endmodule
